>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define BPEC_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define BPEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bpec_pkg.sv
// ----------------------------------------------------------------------------
// bpec_pkg
// Shared constants and types for the ball pair elastic collision pipeline.
// ----------------------------------------------------------------------------
package bpec_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int DEF_WORD_BITS = 32;
    localparam int QUOT_BITS     = 63;   // quotient bits resolved by the divider
    localparam int CLAMP_BIT     = 62;   // velocity change clamps at 2^62

    typedef enum logic [1:0] {
        OUT_UPDATED     = 2'd0,
        OUT_SAME_CENTRE = 2'd1,
        OUT_SEPARATING  = 2'd2,
        OUT_ZERO_MASS   = 2'd3
    } outcome_t;

endpackage

>>> rtl/core/ball_pair_elastic_collision.sv
// ----------------------------------------------------------------------------
// ball_pair_elastic_collision
// Elastic collision of two circles: new velocities from positions,
// velocities and masses, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per body pair:
//   positions, velocities and masses of both bodies, Q16.16.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   the four new velocities, saturated, and an outcome code.
//   Throughput is one word per cycle while the receiver does not stall;
//   the depth is set by the restoring divider, one quotient bit per
//   stage over 63 stages, four lanes side by side.
//   The approach check register is written through cfg_write_enable /
//   cfg_write_data; the user must write it only while the pipeline is empty (not enforced).
//   Reset empties the pipeline and sets the approach check.
//   When the receiver stalls the whole pipeline holds; in_ready follows
//   out_ready whenever a result is waiting.
// ----------------------------------------------------------------------------
module ball_pair_elastic_collision
    import bpec_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_enable,
    input  logic                  cfg_write_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FIELD_BITS-1:0] first_position_x,
    input  logic [FIELD_BITS-1:0] first_position_y,
    input  logic [FIELD_BITS-1:0] first_velocity_x,
    input  logic [FIELD_BITS-1:0] first_velocity_y,
    input  logic [FIELD_BITS-1:0] first_mass,
    input  logic [FIELD_BITS-1:0] second_position_x,
    input  logic [FIELD_BITS-1:0] second_position_y,
    input  logic [FIELD_BITS-1:0] second_velocity_x,
    input  logic [FIELD_BITS-1:0] second_velocity_y,
    input  logic [FIELD_BITS-1:0] second_mass,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_BITS-1:0] new_first_velocity_x,
    output logic [FIELD_BITS-1:0] new_first_velocity_y,
    output logic [FIELD_BITS-1:0] new_second_velocity_x,
    output logic [FIELD_BITS-1:0] new_second_velocity_y,
    output logic [1:0]            outcome
);

    localparam int W      = WORD_BITS;
    localparam int D_W    = W + 1;
    localparam int P_W    = 2 * D_W;
    localparam int S_W    = P_W + 1;
    localparam int M_W    = W + 1;
    localparam int HI_W   = S_W - W;
    localparam int DEN_W  = M_W + S_W;
    localparam int L2_W   = DEN_W - 2 * W;
    localparam int NUM_W  = DEN_W + D_W;
    localparam int QB     = QUOT_BITS;
    localparam int SUM_W  = QB + 2;
    localparam int LAT    = QB + 11;

    localparam logic [QB:0] QLIM = (QB + 1)'(1) << CLAMP_BIT;
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [3:0][W-1:0] v;
        logic              sdx;
        logic              sdy;
        logic              pneg;
        outcome_t          oc;
    } ctx_t;

    typedef struct packed {
        ctx_t           ctx;
        logic [D_W-1:0] mdx, mdy, mux, muy;
        logic           sux, suy, same;
        logic [M_W-1:0] msum, m1x2, m2x2;
    } s1_t;

    typedef struct packed {
        ctx_t           ctx;
        logic [P_W-1:0] tx, ty, ddx, ddy;
        logic           sx, sy, same;
        logic [M_W-1:0] msum, m1x2, m2x2;
        logic [D_W-1:0] mdx, mdy;
    } s2_t;

    typedef struct packed {
        ctx_t           ctx;
        logic [S_W-1:0] pm, dd;
        logic [M_W-1:0] msum, m1x2, m2x2;
        logic [D_W-1:0] mdx, mdy;
    } s3_t;

    typedef struct packed {
        ctx_t                ctx;
        logic [M_W+W-1:0]    den_lo, s1_lo, s2_lo;
        logic [M_W+HI_W-1:0] den_hi, s1_hi, s2_hi;
        logic [D_W-1:0]      mdx, mdy;
    } s4_t;

    typedef struct packed {
        ctx_t                  ctx;
        logic [DEN_W-1:0]      den;
        logic [1:0][DEN_W-1:0] sv;
        logic [D_W-1:0]        mdx, mdy;
    } s5_t;

    typedef struct packed {
        ctx_t                      ctx;
        logic [DEN_W-1:0]          den;
        logic [3:0][W+D_W-1:0]     pp0, pp1;
        logic [3:0][L2_W+D_W-1:0]  pp2;
    } s6_t;

    typedef struct packed {
        ctx_t                      ctx;
        logic [DEN_W-1:0]          den;
        logic [3:0][NUM_W-1:0]     a;
        logic [3:0][L2_W+D_W-1:0]  pp2;
    } s7_t;

    typedef struct packed {
        ctx_t                  ctx;
        logic [DEN_W-1:0]      den;
        logic [3:0][NUM_W-1:0] num;
    } s8_t;

    typedef struct packed {
        logic             ovf;
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    low;
        logic [QB-1:0]    q;
    } dl_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [DEN_W-1:0] den;
        dl_t [3:0]        lane;
    } dst_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [3:0][QB-1:0] q;
    } rnd_t;

    logic            cfg_reg;
    logic [LAT-1:0]  vld_reg;
    logic            adv;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    s7_t  s7_reg, s7_next;
    s8_t  s8_reg, s8_next;
    dst_t dv_reg  [QB+1];
    dst_t dv_next [QB+1];
    rnd_t rnd_reg, rnd_next;
    logic [3:0][W-1:0] res_reg, res_next;
    outcome_t          oc_reg;

    logic signed [D_W-1:0] dx, dy, ux, uy;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= 1'b1;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                cfg_reg <= cfg_write_data;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
            end
        end
    end

    // stage 1: differences, magnitudes, mass sums
    assign dx = D_W'($signed(second_position_x[W-1:0])) - D_W'($signed(first_position_x[W-1:0]));
    assign dy = D_W'($signed(second_position_y[W-1:0])) - D_W'($signed(first_position_y[W-1:0]));
    assign ux = D_W'($signed(second_velocity_x[W-1:0])) - D_W'($signed(first_velocity_x[W-1:0]));
    assign uy = D_W'($signed(second_velocity_y[W-1:0])) - D_W'($signed(first_velocity_y[W-1:0]));

    always_comb
    begin
        s1_next.ctx.v[0] = first_velocity_x[W-1:0];
        s1_next.ctx.v[1] = first_velocity_y[W-1:0];
        s1_next.ctx.v[2] = second_velocity_x[W-1:0];
        s1_next.ctx.v[3] = second_velocity_y[W-1:0];
        s1_next.ctx.sdx  = dx[D_W-1];
        s1_next.ctx.sdy  = dy[D_W-1];
        s1_next.ctx.pneg = 1'b0;
        s1_next.ctx.oc   = OUT_UPDATED;
        s1_next.mdx  = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
        s1_next.mdy  = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
        s1_next.mux  = ux[D_W-1] ? D_W'(-ux) : D_W'(ux);
        s1_next.muy  = uy[D_W-1] ? D_W'(-uy) : D_W'(uy);
        s1_next.sux  = ux[D_W-1];
        s1_next.suy  = uy[D_W-1];
        s1_next.same = (dx == '0) && (dy == '0);
        s1_next.msum = M_W'(first_mass[W-1:0]) + M_W'(second_mass[W-1:0]);
        s1_next.m1x2 = {first_mass[W-1:0], 1'b0};
        s1_next.m2x2 = {second_mass[W-1:0], 1'b0};
    end

    // stage 2: dot product terms and squared distance terms
    always_comb
    begin
        s2_next.ctx  = s1_reg.ctx;
        s2_next.tx   = s1_reg.mux * s1_reg.mdx;
        s2_next.ty   = s1_reg.muy * s1_reg.mdy;
        s2_next.ddx  = s1_reg.mdx * s1_reg.mdx;
        s2_next.ddy  = s1_reg.mdy * s1_reg.mdy;
        s2_next.sx   = s1_reg.sux ^ s1_reg.ctx.sdx;
        s2_next.sy   = s1_reg.suy ^ s1_reg.ctx.sdy;
        s2_next.same = s1_reg.same;
        s2_next.msum = s1_reg.msum;
        s2_next.m1x2 = s1_reg.m1x2;
        s2_next.m2x2 = s1_reg.m2x2;
        s2_next.mdx  = s1_reg.mdx;
        s2_next.mdy  = s1_reg.mdy;
    end

    // stage 3: signed dot product, squared distance sum, case decision
    always_comb
    begin
        s3_next.ctx  = s2_reg.ctx;
        s3_next.dd   = S_W'(s2_reg.ddx) + S_W'(s2_reg.ddy);
        s3_next.msum = s2_reg.msum;
        s3_next.m1x2 = s2_reg.m1x2;
        s3_next.m2x2 = s2_reg.m2x2;
        s3_next.mdx  = s2_reg.mdx;
        s3_next.mdy  = s2_reg.mdy;
        if (s2_reg.sx == s2_reg.sy)
        begin
            s3_next.pm       = S_W'(s2_reg.tx) + S_W'(s2_reg.ty);
            s3_next.ctx.pneg = s2_reg.sx;
        end
        else if (s2_reg.tx >= s2_reg.ty)
        begin
            s3_next.pm       = S_W'(s2_reg.tx - s2_reg.ty);
            s3_next.ctx.pneg = s2_reg.sx;
        end
        else
        begin
            s3_next.pm       = S_W'(s2_reg.ty - s2_reg.tx);
            s3_next.ctx.pneg = s2_reg.sy;
        end
        if (s3_next.pm == '0)
        begin
            s3_next.ctx.pneg = 1'b0;
        end
        if (s2_reg.same)
        begin
            s3_next.ctx.oc = OUT_SAME_CENTRE;
        end
        else if (cfg_reg && !s3_next.ctx.pneg)
        begin
            s3_next.ctx.oc = OUT_SEPARATING;
        end
        else if (s2_reg.msum == '0)
        begin
            s3_next.ctx.oc = OUT_ZERO_MASS;
        end
        else
        begin
            s3_next.ctx.oc = OUT_UPDATED;
        end
    end

    // stage 4: partial products of denominator and scaled projections
    always_comb
    begin
        s4_next.ctx    = s3_reg.ctx;
        s4_next.den_lo = s3_reg.msum * s3_reg.dd[W-1:0];
        s4_next.den_hi = s3_reg.msum * s3_reg.dd[S_W-1:W];
        s4_next.s1_lo  = s3_reg.m2x2 * s3_reg.pm[W-1:0];
        s4_next.s1_hi  = s3_reg.m2x2 * s3_reg.pm[S_W-1:W];
        s4_next.s2_lo  = s3_reg.m1x2 * s3_reg.pm[W-1:0];
        s4_next.s2_hi  = s3_reg.m1x2 * s3_reg.pm[S_W-1:W];
        s4_next.mdx    = s3_reg.mdx;
        s4_next.mdy    = s3_reg.mdy;
    end

    // stage 5: combine partials
    always_comb
    begin
        s5_next.ctx   = s4_reg.ctx;
        s5_next.den   = DEN_W'(s4_reg.den_lo) + {s4_reg.den_hi, {W{1'b0}}};
        s5_next.sv[0] = DEN_W'(s4_reg.s1_lo) + {s4_reg.s1_hi, {W{1'b0}}};
        s5_next.sv[1] = DEN_W'(s4_reg.s2_lo) + {s4_reg.s2_hi, {W{1'b0}}};
        s5_next.mdx   = s4_reg.mdx;
        s5_next.mdy   = s4_reg.mdy;
    end

    // stage 6: numerator partial products, lanes v1x v1y v2x v2y
    always_comb
    begin
        s6_next.ctx = s5_reg.ctx;
        s6_next.den = s5_reg.den;
        for (int l = 0; l < 4; l++)
        begin
            if (l % 2 == 1)
            begin
                s6_next.pp0[l] = s5_reg.sv[l>>1][W-1:0] * s5_reg.mdy;
                s6_next.pp1[l] = s5_reg.sv[l>>1][2*W-1:W] * s5_reg.mdy;
                s6_next.pp2[l] = s5_reg.sv[l>>1][DEN_W-1:2*W] * s5_reg.mdy;
            end
            else
            begin
                s6_next.pp0[l] = s5_reg.sv[l>>1][W-1:0] * s5_reg.mdx;
                s6_next.pp1[l] = s5_reg.sv[l>>1][2*W-1:W] * s5_reg.mdx;
                s6_next.pp2[l] = s5_reg.sv[l>>1][DEN_W-1:2*W] * s5_reg.mdx;
            end
        end
    end

    // stages 7, 8: numerator sums
    always_comb
    begin
        s7_next.ctx = s6_reg.ctx;
        s7_next.den = s6_reg.den;
        s7_next.pp2 = s6_reg.pp2;
        for (int l = 0; l < 4; l++)
        begin
            s7_next.a[l] = NUM_W'(s6_reg.pp0[l]) + NUM_W'({s6_reg.pp1[l], {W{1'b0}}});
        end
        s8_next.ctx = s7_reg.ctx;
        s8_next.den = s7_reg.den;
        for (int l = 0; l < 4; l++)
        begin
            s8_next.num[l] = s7_reg.a[l] + {s7_reg.pp2[l], {(2*W){1'b0}}};
        end
    end

    function automatic dst_t div_step(dst_t cur);
        dst_t           nxt;
        logic [DEN_W:0] t;
        logic           ge;
        nxt = cur;
        for (int l = 0; l < 4; l++)
        begin
            t  = {cur.lane[l].rem, cur.lane[l].low[QB-1]};
            ge = t >= {1'b0, cur.den};
            nxt.lane[l].rem = ge ? DEN_W'(t - {1'b0, cur.den}) : t[DEN_W-1:0];
            nxt.lane[l].low = {cur.lane[l].low[QB-2:0], 1'b0};
            nxt.lane[l].q   = {cur.lane[l].q[QB-2:0], ge};
        end
        return nxt;
    endfunction

    // stage 9: overflow check and divider seed; then one quotient bit per stage
    always_comb
    begin
        logic [NUM_W-1:0] hi;
        dv_next[0].ctx = s8_reg.ctx;
        dv_next[0].den = s8_reg.den;
        for (int l = 0; l < 4; l++)
        begin
            hi = s8_reg.num[l] >> QB;
            dv_next[0].lane[l].ovf = hi >= NUM_W'(s8_reg.den);
            dv_next[0].lane[l].rem = hi[DEN_W-1:0];
            dv_next[0].lane[l].low = s8_reg.num[l][QB-1:0];
            dv_next[0].lane[l].q   = '0;
        end
        for (int k = 1; k <= QB; k++)
        begin
            dv_next[k] = div_step(dv_reg[k-1]);
        end
    end

    // round half away from zero on magnitude, clamp at 2^62, zero unless outcome is updated
    always_comb
    begin
        logic [QB:0] qr;
        logic        rb;
        rnd_next.ctx = dv_reg[QB].ctx;
        for (int l = 0; l < 4; l++)
        begin
            rb = {dv_reg[QB].lane[l].rem, 1'b0} >= {1'b0, dv_reg[QB].den};
            qr = {1'b0, dv_reg[QB].lane[l].q} + (QB + 1)'(rb);
            if (dv_reg[QB].ctx.oc != OUT_UPDATED)
            begin
                rnd_next.q[l] = '0;
            end
            else if (dv_reg[QB].lane[l].ovf || qr >= QLIM)
            begin
                rnd_next.q[l] = QLIM[QB-1:0];
            end
            else
            begin
                rnd_next.q[l] = qr[QB-1:0];
            end
        end
    end

    // apply change and saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] vext;
        logic signed [SUM_W-1:0] qext;
        logic signed [SUM_W-1:0] n;
        logic                    neg;
        for (int l = 0; l < 4; l++)
        begin
            vext = SUM_W'($signed(rnd_reg.ctx.v[l]));
            qext = $signed(SUM_W'(rnd_reg.q[l]));
            neg  = (l >= 2) ^ rnd_reg.ctx.pneg
                   ^ ((l % 2 == 1) ? rnd_reg.ctx.sdy : rnd_reg.ctx.sdx);
            n    = neg ? vext - qext : vext + qext;
            if (n > SAT_HI)
            begin
                res_next[l] = SAT_HI[W-1:0];
            end
            else if (n < SAT_LO)
            begin
                res_next[l] = SAT_LO[W-1:0];
            end
            else
            begin
                res_next[l] = n[W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            s6_reg  <= s6_next;
            s7_reg  <= s7_next;
            s8_reg  <= s8_next;
            dv_reg  <= dv_next;
            rnd_reg <= rnd_next;
            res_reg <= res_next;
            oc_reg  <= rnd_reg.ctx.oc;
        end
    end

    assign new_first_velocity_x  = FIELD_BITS'($signed(res_reg[0]));
    assign new_first_velocity_y  = FIELD_BITS'($signed(res_reg[1]));
    assign new_second_velocity_x = FIELD_BITS'($signed(res_reg[2]));
    assign new_second_velocity_y = FIELD_BITS'($signed(res_reg[3]));
    assign outcome               = oc_reg;

endmodule

>>> rtl/core/bpec_checker.sv
// ----------------------------------------------------------------------------
// bpec_checker
// Port-level checks for ball_pair_elastic_collision, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpec_checker
    import bpec_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [FIELD_BITS-1:0] new_first_velocity_x,
    input logic [FIELD_BITS-1:0] new_first_velocity_y,
    input logic [FIELD_BITS-1:0] new_second_velocity_x,
    input logic [FIELD_BITS-1:0] new_second_velocity_y,
    input logic [1:0]            outcome
);

    // held result word stays put
    `BPEC_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(new_first_velocity_x) && $stable(new_first_velocity_y) && $stable(new_second_velocity_x) && $stable(new_second_velocity_y) && $stable(outcome), "output word changed while stalled")

    // pipeline advances exactly when the output slot is free or drained
    `BPEC_ASSERT_RST(a_ready_link, clk, rst_n, in_ready == (!out_valid || out_ready), "in_ready does not follow output space")

    // reset empties the pipeline
    `BPEC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid during reset")

endmodule

bind ball_pair_elastic_collision bpec_checker u_bpec_checker (.*);
